// ===== src/quaternion_blend_crossover_assert.svh =====
// Assertion macros for the quaternion blend crossover block.
// Used by the top level only; the assertions drop out when SYNTH is defined.
`ifndef QUATERNION_BLEND_CROSSOVER_ASSERT_SVH
`define QUATERNION_BLEND_CROSSOVER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication under a synchronous active-low reset.
`define QBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qbc assertion failed");
// Next-cycle implication under a synchronous active-low reset.
`define QBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qbc assertion failed");
`else
`define QBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QBC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/qbc_pkg.sv =====
// Shared widths and types for the quaternion blend crossover pipeline.
// No dependencies; used by every module of the block.
`default_nettype none
package qbc_pkg;
  // Blended component with eight guard bits: magnitude stays below 2^26.
  localparam int QW = 28;
  // Sum of four squared components.
  localparam int SW = 56;
  // Normalized square-root operand: top bit lands at bit 60 or 61.
  localparam int XW = 62;
  // Square root of the normalized operand.
  localparam int NW = 31;
  // Half of the normalizing shift.
  localparam int KW = 5;
  // Partial remainder width in the root and quotient cells.
  localparam int RMW = 33;
  // Number of even-shift normalizing cells (shifts 32, 16, 8, 4, 2).
  localparam int NS = 5;
  // One root bit per cell.
  localparam int SQ = NW;

  typedef struct packed {
    logic flip;
    logic degen;
  } flags_t;
endpackage
`default_nettype wire

// ===== src/qbc_blend.sv =====
// Front end: alignment, blend and sum of squares in six register stages.
// Depends on qbc_pkg.
`default_nettype none
module qbc_blend #(
  parameter int RAND_BITS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [3:0][15:0]                a,
  input  logic [3:0][15:0]                b,
  input  logic [3:0][15:0]                r,
  output logic [3:0][qbc_pkg::QW-1:0]     q,
  output logic [qbc_pkg::SW-1:0]          s,
  output qbc_pkg::flags_t                 flags
);
  localparam int QW = qbc_pkg::QW;
  localparam int SW = qbc_pkg::SW;
  localparam int RB = (RAND_BITS < 16) ? RAND_BITS : 16;
  localparam int DW = 18;
  localparam int PW = DW + RB + 1;
  localparam int CW = RAND_BITS + 21;
  localparam int SH = RAND_BITS - 7;

  logic [3:0][31:0]     prod0_r;
  logic [3:0][15:0]     a0_r, b0_r, a1_r, a2_r;
  logic [3:0][RB-1:0]   r0_r, r1_r;
  logic                 neg1_r, flip2_r, flip3_r, flip4_r;
  logic [3:0][DW-1:0]   dp1_r, dn1_r, d2_r;
  logic [3:0][PW-1:0]   dr2_r;
  logic [3:0][QW-1:0]   q3_r, q4_r, q5_r;
  logic [3:0][SW-1:0]   sq4_r;
  logic [SW-1:0]        s5_r;
  qbc_pkg::flags_t      fl5_r;

  logic [3:0][31:0]     prod0_nxt;
  logic                 neg1_nxt;
  logic [3:0][DW-1:0]   dp1_nxt, dn1_nxt, d2_nxt;
  logic [3:0][PW-1:0]   dr2_nxt;
  logic [3:0][QW-1:0]   q3_nxt;
  logic [3:0][SW-1:0]   sq4_nxt;
  logic [SW-1:0]        s5_nxt;

  // Stage 0: the four products of the dot product.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod0_nxt[i] = $signed(a[i]) * $signed(b[i]);
    end
  end

  // Stage 1: dot sign plus both candidate differences.
  always_comb begin
    logic signed [33:0] dot;
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + $signed({{2{prod0_r[i][31]}}, prod0_r[i]});
    end
    neg1_nxt = dot[33];
    for (int i = 0; i < 4; i++) begin
      dp1_nxt[i] = {{2{b0_r[i][15]}}, b0_r[i]} - {{2{a0_r[i][15]}}, a0_r[i]};
      dn1_nxt[i] = DW'(0) - {{2{b0_r[i][15]}}, b0_r[i]} - {{2{a0_r[i][15]}}, a0_r[i]};
    end
  end

  // Stage 2: pick the aligned difference and scale it by the fraction.
  always_comb begin
    logic signed [PW-1:0] de, re;
    for (int i = 0; i < 4; i++) begin
      d2_nxt[i] = neg1_r ? dn1_r[i] : dp1_r[i];
      de = $signed({{(PW-DW){d2_nxt[i][DW-1]}}, d2_nxt[i]});
      re = $signed({{(PW-RB){1'b0}}, r1_r[i]});
      dr2_nxt[i] = de * re;
    end
  end

  // Stage 3: exact blend, then round to nearest down to the guard bits.
  always_comb begin
    logic signed [CW-1:0] ae, de, dre, c;
    for (int i = 0; i < 4; i++) begin
      ae  = $signed({{(CW-16){a2_r[i][15]}}, a2_r[i]});
      de  = $signed({{(CW-DW){d2_r[i][DW-1]}}, d2_r[i]});
      dre = $signed({{(CW-PW){dr2_r[i][PW-1]}}, dr2_r[i]});
      c = (ae <<< (RAND_BITS + 1)) - (de <<< RAND_BITS) + (dre <<< 2);
      c = c + (CW'(1) <<< (SH - 1));
      c = c >>> SH;
      q3_nxt[i] = c[QW-1:0];
    end
  end

  // Stage 4: squares of the blended components.
  always_comb begin
    logic signed [SW-1:0] qe;
    for (int i = 0; i < 4; i++) begin
      qe = $signed({{(SW-QW){q3_r[i][QW-1]}}, q3_r[i]});
      sq4_nxt[i] = qe * qe;
    end
  end

  // Stage 5: sum of squares.
  assign s5_nxt = sq4_r[0] + sq4_r[1] + sq4_r[2] + sq4_r[3];

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r <= prod0_nxt;
      a0_r    <= a;
      b0_r    <= b;
      for (int i = 0; i < 4; i++) begin
        r0_r[i] <= r[i][RB-1:0];
      end
      neg1_r  <= neg1_nxt;
      dp1_r   <= dp1_nxt;
      dn1_r   <= dn1_nxt;
      a1_r    <= a0_r;
      r1_r    <= r0_r;
      d2_r    <= d2_nxt;
      dr2_r   <= dr2_nxt;
      a2_r    <= a1_r;
      flip2_r <= neg1_r;
      q3_r    <= q3_nxt;
      flip3_r <= flip2_r;
      sq4_r   <= sq4_nxt;
      q4_r    <= q3_r;
      flip4_r <= flip3_r;
      s5_r    <= s5_nxt;
      q5_r    <= q4_r;
      fl5_r.flip  <= flip4_r;
      fl5_r.degen <= (s5_nxt == '0);
    end
  end

  assign q     = q5_r;
  assign s     = s5_r;
  assign flags = fl5_r;
endmodule
`default_nettype wire

// ===== src/qbc_norm_cell.sv =====
// One normalizing cell: shifts the root operand left by an even amount
// when its top bits are clear. Depends on qbc_pkg.
`default_nettype none
module qbc_norm_cell #(
  parameter int AMT = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [qbc_pkg::XW-1:0]   x_in,
  input  logic [qbc_pkg::KW-1:0]   k_in,
  output logic [qbc_pkg::XW-1:0]   x_out,
  output logic [qbc_pkg::KW-1:0]   k_out
);
  localparam int XW = qbc_pkg::XW;
  localparam int KW = qbc_pkg::KW;

  logic [XW-1:0] x_r, x_nxt;
  logic [KW-1:0] k_r, k_nxt;

  // Shift when the top AMT bits are all zero.
  always_comb begin
    if (x_in[XW-1 -: AMT] == '0) begin
      x_nxt = x_in << AMT;
      k_nxt = k_in + KW'(AMT / 2);
    end else begin
      x_nxt = x_in;
      k_nxt = k_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      k_r <= k_nxt;
    end
  end

  assign x_out = x_r;
  assign k_out = k_r;
endmodule
`default_nettype wire

// ===== src/qbc_sqrt_cell.sv =====
// One restoring square-root cell: takes two operand bits, yields one root bit.
// Depends on qbc_pkg.
`default_nettype none
module qbc_sqrt_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qbc_pkg::XW-1:0]    x_in,
  input  logic [qbc_pkg::RMW-1:0]   rem_in,
  input  logic [qbc_pkg::NW-1:0]    root_in,
  output logic [qbc_pkg::XW-1:0]    x_out,
  output logic [qbc_pkg::RMW-1:0]   rem_out,
  output logic [qbc_pkg::NW-1:0]    root_out
);
  localparam int XW  = qbc_pkg::XW;
  localparam int RMW = qbc_pkg::RMW;
  localparam int NW  = qbc_pkg::NW;

  logic [XW-1:0]  x_r;
  logic [RMW-1:0] rem_r, rem_nxt;
  logic [NW-1:0]  root_r, root_nxt;

  // Trial subtraction of 4*root+1 from the extended remainder.
  always_comb begin
    logic [RMW+1:0] cur, trial;
    cur   = {rem_in, x_in[XW-1 -: 2]};
    trial = {{(RMW+2-NW-2){1'b0}}, root_in, 2'b01};
    if (cur >= trial) begin
      rem_nxt  = RMW'(cur - trial);
      root_nxt = {root_in[NW-2:0], 1'b1};
    end else begin
      rem_nxt  = cur[RMW-1:0];
      root_nxt = {root_in[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_in << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign x_out    = x_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
endmodule
`default_nettype wire

// ===== src/qbc_div_cell.sv =====
// One restoring division cell: yields one quotient bit of the scaled
// component over the norm. Depends on qbc_pkg.
`default_nettype none
module qbc_div_cell #(
  parameter bit FIRST = 1'b0,
  parameter int QBW   = 15
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qbc_pkg::RMW-1:0]   rem_in,
  input  logic [QBW-1:0]            quo_in,
  input  logic [qbc_pkg::NW-1:0]    n,
  output logic [qbc_pkg::RMW-1:0]   rem_out,
  output logic [QBW-1:0]            quo_out
);
  localparam int RMW = qbc_pkg::RMW;

  logic [RMW-1:0] rem_r, rem_nxt;
  logic [QBW-1:0] quo_r, quo_nxt;

  // The first cell compares the operand as is; later cells double it.
  always_comb begin
    logic [RMW-1:0] t, ne;
    t  = FIRST ? rem_in : (rem_in << 1);
    ne = {{(RMW-qbc_pkg::NW){1'b0}}, n};
    if (t >= ne) begin
      rem_nxt = t - ne;
      quo_nxt = {quo_in[QBW-2:0], 1'b1};
    end else begin
      rem_nxt = t;
      quo_nxt = {quo_in[QBW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_out = rem_r;
  assign quo_out = quo_r;
endmodule
`default_nettype wire

// ===== src/quaternion_blend_crossover.sv =====
// Quaternion blend crossover with normalization, fully pipelined.
// The pipeline has 6 blend stages, 5 normalizing cells, 31 square-root cells,
// 1 scaling stage, FRAC_BITS + 1 quotient cells and 1 output.
// Throughput is one item per cycle; the whole chain stalls only while the
// output register holds an item that is not taken.
// Synchronous active-low reset clears the stage valid bits only.
`default_nettype none
`include "quaternion_blend_crossover_assert.svh"
module quaternion_blend_crossover #(
  parameter int FRAC_BITS = 14,
  parameter int RAND_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, rand_x, rand_y, rand_z, rand_w
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // child_x, child_y, child_z, child_w
  output logic [63:0]  out_tdata,
  // second_flipped, degenerate
  output logic [1:0]   out_tuser
);
  localparam int QW  = qbc_pkg::QW;
  localparam int SW  = qbc_pkg::SW;
  localparam int XW  = qbc_pkg::XW;
  localparam int NW  = qbc_pkg::NW;
  localparam int KW  = qbc_pkg::KW;
  localparam int RMW = qbc_pkg::RMW;
  localparam int NS  = qbc_pkg::NS;
  localparam int SQ  = qbc_pkg::SQ;
  localparam int LB  = 6;
  localparam int DV  = FRAC_BITS + 1;
  localparam int OW  = FRAC_BITS + 2;
  localparam int FL  = NS + SQ + 1 + DV;
  localparam int LAT = LB + NS + SQ + 1 + DV + 1;
  localparam int LIMV = (FRAC_BITS > 15) ? 32768 : (1 << FRAC_BITS);
  localparam logic signed [16:0] LIM_HI = 17'((LIMV > 32767) ? 32767 : LIMV);
  localparam logic signed [16:0] LIM_LO = -17'(LIMV);

  logic             en;
  logic             in_fire;
  logic [LAT-1:0]   vld_r, vld_nxt;

  logic [3:0][15:0] a_in, b_in, r_in;
  logic [3:0][QW-1:0] q_b;
  logic [SW-1:0]      s_b;
  qbc_pkg::flags_t    fl_b;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;

  // Unpack the input item into lanes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_in[i] = in_tdata[16*i +: 16];
      b_in[i] = in_tdata[64 + 16*i +: 16];
      r_in[i] = in_tdata[128 + 16*i +: 16];
    end
  end

  // Stage valid bits move with the pipeline enable.
  assign vld_nxt = {vld_r[LAT-2:0], in_fire};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  qbc_blend #(.RAND_BITS(RAND_BITS)) u_blend (
    .clk(clk), .en(en), .a(a_in), .b(b_in), .r(r_in),
    .q(q_b), .s(s_b), .flags(fl_b)
  );

  // Normalizing cells.
  logic [XW-1:0] x_nm [NS+1];
  logic [KW-1:0] k_nm [NS+1];
  assign x_nm[0] = {{(XW-SW){1'b0}}, s_b};
  assign k_nm[0] = '0;
  for (genvar j = 0; j < NS; j++) begin : g_norm
    qbc_norm_cell #(.AMT(32 >> j)) u_cell (
      .clk(clk), .en(en), .x_in(x_nm[j]), .k_in(k_nm[j]),
      .x_out(x_nm[j+1]), .k_out(k_nm[j+1])
    );
  end

  // Square-root cells, one root bit each.
  logic [XW-1:0]  x_sq    [SQ+1];
  logic [RMW-1:0] rem_sq  [SQ+1];
  logic [NW-1:0]  root_sq [SQ+1];
  assign x_sq[0]    = x_nm[NS];
  assign rem_sq[0]  = '0;
  assign root_sq[0] = '0;
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    qbc_sqrt_cell u_cell (
      .clk(clk), .en(en), .x_in(x_sq[j]), .rem_in(rem_sq[j]), .root_in(root_sq[j]),
      .x_out(x_sq[j+1]), .rem_out(rem_sq[j+1]), .root_out(root_sq[j+1])
    );
  end

  // Side lines that keep components, shift and flags aligned with the cells.
  logic [3:0][QW-1:0] qd_r  [NS+SQ];
  logic [KW-1:0]      kd_r  [SQ];
  qbc_pkg::flags_t    fd_r  [FL];
  logic [NW-1:0]      ndl_r [DV];
  logic [3:0]         sgl_r [DV];

  // Scaling stage registers.
  logic [3:0][RMW-1:0] m_s_r, m_s_nxt;
  logic [NW-1:0]       n_s_r;
  logic [3:0]          sg_s_r, sg_s_nxt;

  // Magnitude of each component shifted by half the normalizing shift.
  always_comb begin
    logic [QW-1:0] mag;
    logic [63:0]   wide;
    for (int i = 0; i < 4; i++) begin
      sg_s_nxt[i] = qd_r[NS+SQ-1][i][QW-1];
      mag  = sg_s_nxt[i] ? (QW'(0) - qd_r[NS+SQ-1][i]) : qd_r[NS+SQ-1][i];
      wide = {{(64-QW){1'b0}}, mag} << kd_r[SQ-1];
      m_s_nxt[i] = wide[RMW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r[0] <= q_b;
      for (int j = 1; j < NS + SQ; j++) begin
        qd_r[j] <= qd_r[j-1];
      end
      kd_r[0] <= k_nm[NS];
      for (int j = 1; j < SQ; j++) begin
        kd_r[j] <= kd_r[j-1];
      end
      fd_r[0] <= fl_b;
      for (int j = 1; j < FL; j++) begin
        fd_r[j] <= fd_r[j-1];
      end
      m_s_r    <= m_s_nxt;
      n_s_r    <= root_sq[SQ];
      sg_s_r   <= sg_s_nxt;
      ndl_r[0] <= n_s_r;
      sgl_r[0] <= sg_s_r;
      for (int j = 1; j < DV; j++) begin
        ndl_r[j] <= ndl_r[j-1];
        sgl_r[j] <= sgl_r[j-1];
      end
    end
  end

  // Quotient cells, one chain per lane.
  logic [RMW-1:0] rem_dv [4][DV+1];
  logic [DV-1:0]  quo_dv [4][DV+1];
  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign rem_dv[l][0] = m_s_r[l];
    assign quo_dv[l][0] = '0;
    for (genvar j = 0; j < DV; j++) begin : g_div
      if (j == 0) begin : g_first
        qbc_div_cell #(.FIRST(1'b1), .QBW(DV)) u_cell (
          .clk(clk), .en(en), .rem_in(rem_dv[l][j]), .quo_in(quo_dv[l][j]),
          .n(n_s_r), .rem_out(rem_dv[l][j+1]), .quo_out(quo_dv[l][j+1])
        );
      end else begin : g_next
        qbc_div_cell #(.FIRST(1'b0), .QBW(DV)) u_cell (
          .clk(clk), .en(en), .rem_in(rem_dv[l][j]), .quo_in(quo_dv[l][j]),
          .n(ndl_r[j-1]), .rem_out(rem_dv[l][j+1]), .quo_out(quo_dv[l][j+1])
        );
      end
    end
  end

  // Output stage: round to nearest, clamp to 1.0, apply sign, saturate; degenerate items give zero.
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;
  qbc_pkg::flags_t fl_o;
  assign fl_o = fd_r[FL-1];

  always_comb begin
    logic [RMW:0]  sum;
    logic [RMW:0]  ne;
    logic [OW-1:0] res;
    logic [16:0]   m17;
    logic [16:0]   v17;
    ne = {{(RMW+1-NW){1'b0}}, ndl_r[DV-1]};
    for (int i = 0; i < 4; i++) begin
      sum = {1'b0, rem_dv[i][DV]} + (ne >> 1);
      res = OW'(quo_dv[i][DV]) + OW'(sum >= ne);
      if (res > OW'(LIMV)) begin
        res = OW'(LIMV);
      end
      m17 = 17'(res);
      if (sgl_r[DV-1][i]) begin
        v17 = 17'(0) - m17;
      end else if (m17 > 17'd32767) begin
        v17 = 17'd32767;
      end else begin
        v17 = m17;
      end
      out_data_nxt[16*i +: 16] = fl_o.degen ? 16'd0 : v17[15:0];
    end
    out_user_nxt = {fl_o.degen, fl_o.flip};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks on the result and on pipeline entry.
  logic signed [16:0] cx_s, cw_s;
  assign cx_s = $signed({out_tdata[15], out_tdata[15:0]});
  assign cw_s = $signed({out_tdata[63], out_tdata[63:48]});

  `QBC_ASSERT_IMP(a_degen_zero, clk, rst_n, out_tvalid && out_tuser[1], out_tdata == 64'd0)
  `QBC_ASSERT_IMP(a_range_x, clk, rst_n, out_tvalid, (cx_s <= LIM_HI) && (cx_s >= LIM_LO))
  `QBC_ASSERT_IMP(a_range_w, clk, rst_n, out_tvalid, (cw_s <= LIM_HI) && (cw_s >= LIM_LO))
  `QBC_ASSERT_NXT(a_entry, clk, rst_n, in_tvalid && in_tready, vld_r[0])
endmodule
`default_nettype wire

// ===== tb/tb_quaternion_blend_crossover.sv =====
// Testbench for the quaternion blend crossover block: random and directed parents.
// Depends on the block's top module; a scoreboard class predicts each child in full.
`timescale 1ns / 1ps

class qbc_scoreboard;
  logic [65:0] pending_children[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint signed sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  static function longint unsigned root64(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Predict the normalized child for one accepted item.
  function void note_parents(logic [191:0] d);
    longint signed a[4], b[4], q[4], dot, df, c, v;
    longint unsigned s, t, n, mag, num, res;
    int p, k, i;
    logic flip;
    logic [63:0] child;
    dot = 0;
    s = 0;
    for (i = 0; i < 4; i++) begin
      a[i] = sx16(d[16*i +: 16]);
      b[i] = sx16(d[64 + 16*i +: 16]);
      dot += a[i] * b[i];
    end
    flip = dot < 0;
    if (flip) for (i = 0; i < 4; i++) b[i] = -b[i];
    for (i = 0; i < 4; i++) begin
      df = b[i] - a[i];
      c = a[i] * 131072 - df * 65536 + df * longint'({48'd0, d[128 + 16*i +: 16]}) * 4;
      q[i] = (c + 256) >>> 9;
      s += longint'(q[i] * q[i]);
    end
    child = '0;
    if (s == 0) begin
      pending_children.push_back({2'b01 | {flip, 1'b0}, child});
      return;
    end
    p = 0;
    t = s;
    while (t > 1) begin
      t = t >> 1;
      p++;
    end
    k = (61 - p) / 2;
    n = root64(s << (2 * k));
    for (i = 0; i < 4; i++) begin
      mag = q[i] < 0 ? -q[i] : q[i];
      num = mag << (14 + k);
      res = (num + n / 2) / n;
      if (res > 16384) res = 16384;
      v = q[i] < 0 ? -longint'(res) : longint'(res);
      child[16*i +: 16] = v[15:0];
    end
    pending_children.push_back({flip, 1'b0, child});
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Compare one child against the oldest prediction.
  task check_child(logic [63:0] data, logic [1:0] user);
    logic [65:0] exp_child;
    int i;
    if (pending_children.size() == 0) begin
      report("child with no prediction");
      return;
    end
    exp_child = pending_children.pop_front();
    for (i = 0; i < 4; i++)
      if (data[16*i +: 16] !== exp_child[16*i +: 16])
        report($sformatf("component %0d got %h want %h", i, data[16*i +: 16],
                         exp_child[16*i +: 16]));
    if (user[0] !== exp_child[65]) report("second_flipped");
    if (user[1] !== exp_child[64]) report("degenerate");
  endtask
endclass

module tb_quaternion_blend_crossover;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic calm = 0;
  qbc_scoreboard sb = new();

  quaternion_blend_crossover u_top (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Receiver: stalls at random except during the calm stretch.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_child(out_tdata, out_tuser);
    out_tready <= calm || ($urandom_range(99) >= 17);
  end

  function automatic logic [15:0] comp_val();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // Offer one item and hold it until accepted; valid drops only while idling.
  task send_parents(logic [191:0] d);
    while (!calm && $urandom_range(99) < 17) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_parents(d);
  endtask

  function automatic logic [191:0] pack_q(logic [63:0] a, logic [63:0] b, logic [63:0] r);
    return {r, b, a};
  endfunction

  initial begin
    logic [191:0] d;
    int i, j;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: identical, opposite, orthogonal, zero and extreme parents.
    send_parents(pack_q({4{16'sd16384}}, {4{16'sd16384}}, '0));
    send_parents(pack_q({4{16'sd16384}}, {4{-16'sd16384}}, {4{16'hFFFF}}));
    send_parents(pack_q({48'd0, 16'sd16384}, {32'd0, 16'sd16384, 16'd0}, {4{16'h8000}}));
    send_parents(pack_q('0, '0, {$urandom, $urandom}));
    send_parents(pack_q({4{16'h8000}}, {4{16'h7FFF}}, {4{16'h4000}}));
    send_parents(pack_q({4{16'h7FFF}}, {4{16'h8000}}, {4{16'hC000}}));
    send_parents(pack_q({4{16'hFFFF}}, {4{16'h0001}}, {4{16'h5555}}));
    send_parents(pack_q({48'd0, 16'd1}, {48'd0, 16'd1}, {4{16'hAAAA}}));
    send_parents(pack_q({4{16'h8000}}, {4{16'h8000}}, {4{16'hFFFF}}));
    for (i = 0; i < 950; i++) begin
      calm = (i >= 400 && i < 550);
      for (j = 0; j < 4; j++) begin
        d[16*j +: 16] = comp_val();
        d[64 + 16*j +: 16] = comp_val();
        d[128 + 16*j +: 16] = 16'($urandom);
      end
      send_parents(d);
    end
    in_tvalid <= 0;
    calm = 0;
    while (sb.pending_children.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_children.size() == 0)
      $display("tb_quaternion_blend_crossover passed");
    else
      $display("tb_quaternion_blend_crossover failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_quaternion_blend_crossover failed");
    $finish;
  end
endmodule
